>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/rvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader version tracker package
// Shared types, request and response layouts and codes.
// ----------------------------------------------------------------------------
package rvt_pkg;

   // Default number of ring entries.
   localparam int RVT_DEPTH = 32;

   // Request kinds.
   localparam logic [1:0] KIND_BEGIN_READ = 2'd0;
   localparam logic [1:0] KIND_END_READ   = 2'd1;
   localparam logic [1:0] KIND_COMMIT     = 2'd2;

   // Status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] reader_version;
      logic [63:0] new_top_ref;
      logic [63:0] new_file_size;
   } rvt_req_type;

   typedef struct packed {
      logic [31:0] snapshot_version;
      logic [31:0] oldest_locked_version;
      logic [63:0] snapshot_top_ref;
      logic [63:0] snapshot_file_size;
      logic [1:0]  status;
   } rvt_rsp_type;

   // One ring entry as stored in memory.
   typedef struct packed {
      logic [31:0] version;
      logic [31:0] count;
   } rvt_entry_type;

   // Command from the front end to the ring engine.
   typedef struct packed {
      logic        go;
      logic [1:0]  kind;
      logic [31:0] reader_version;
      logic [31:0] cur_version;
   } rvt_cmd_type;

   // Completion report from the ring engine.
   typedef struct packed {
      logic        done;
      logic [1:0]  status;
      logic        ring_empty;
      logic [31:0] head_version;
   } rvt_res_type;

endpackage

>>> rtl/reader_version_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader version tracker
// Tracks the committed snapshot and a ring of active reader versions.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge where start is high and busy is low;
// busy then stays high until the request is finished, and exactly one
// response follows on rsp_item, marked by a one-cycle rsp_valid pulse.
// The receiver cannot stall: capture rsp_item whenever rsp_valid is high.
// A request is worked by a small sequencer around the ring memory, and
// every ring access is a read state followed by a check state. An end
// read walks the ring from the head until it finds its version or
// reaches the tail. If its version is the oldest entry and this is its
// last reader, the entry is released together with the emptied entries
// right behind it; otherwise only its count is lowered, never below
// zero. The response is driven in the first cycle in which busy is low,
// and a new request may be accepted in that same cycle.
// The ring memory needs no clearing after reset: only entries between the
// head and tail pointers are ever used.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module reader_version_tracker
   import rvt_pkg::*;
#(
   parameter int DEPTH = RVT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  rvt_req_type req_item,
   output logic        rsp_valid,
   output rvt_rsp_type rsp_item
);

   rvt_cmd_type cmd;
   rvt_res_type res;
   logic        eng_busy;

   // Latched request fields needed when the engine finishes.
   logic [1:0]  kind_ff;
   logic [63:0] new_top_ff;
   logic [63:0] new_size_ff;

   // Committed snapshot.
   logic [31:0] cur_version_ff, cur_version_in;
   logic [63:0] cur_top_ff, cur_top_in;
   logic [63:0] cur_size_ff, cur_size_in;

   // Response register.
   rvt_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff;
   logic [31:0] next_version;

   assign cmd.go             = start & ~eng_busy;
   assign cmd.kind           = req_item.kind;
   assign cmd.reader_version = req_item.reader_version;
   assign cmd.cur_version    = cur_version_ff;

   rvt_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .res   (res),
      .busy  (eng_busy)
   );

   // The snapshot registers only change when a commit finishes, so they are
   // stable for the whole life of a request.
   assign next_version = cur_version_ff + 32'd1;

   always_comb begin
      rsp_in         = rsp_ff;
      cur_version_in = cur_version_ff;
      cur_top_in     = cur_top_ff;
      cur_size_in    = cur_size_ff;
      if (res.done) begin
         rsp_in        = '0;
         rsp_in.status = res.status;
         case (kind_ff)
            KIND_BEGIN_READ: begin
               rsp_in.snapshot_version   = cur_version_ff;
               rsp_in.snapshot_top_ref   = cur_top_ff;
               rsp_in.snapshot_file_size = cur_size_ff;
            end
            KIND_COMMIT: begin
               rsp_in.snapshot_version      = next_version;
               rsp_in.oldest_locked_version = res.ring_empty ? next_version
                                                             : res.head_version;
               cur_version_in = next_version;
               cur_top_in     = new_top_ff;
               cur_size_in    = new_size_ff;
            end
            default: begin
               // End read and the unused kind return only a status.
               rsp_in.snapshot_version = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go) begin
         kind_ff     <= req_item.kind;
         new_top_ff  <= req_item.new_top_ref;
         new_size_ff <= req_item.new_file_size;
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_version_ff <= '0;
         cur_top_ff     <= '0;
         cur_size_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cur_version_ff <= cur_version_in;
         cur_top_ff     <= cur_top_in;
         cur_size_ff    <= cur_size_in;
         rsp_valid_ff   <= res.done;
      end
   end

   assign busy      = eng_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A response is only ever produced by an engine completion.
   `ASSERT_IMPLIES(a_rsp_from_done, clock, reset, rsp_valid_ff, $past(res.done))
   // An accepted request always holds the block busy on the next cycle.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !eng_busy, eng_busy)
   // Each request yields a single one-cycle response pulse.
   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff)

endmodule

>>> rtl/rvt_ring_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rvt_ring_ram
   import rvt_pkg::*;
#(
   parameter int DEPTH = RVT_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  rvt_entry_type            wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output rvt_entry_type            rd_data
);

   rvt_entry_type ring_mem [DEPTH];
   rvt_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= ring_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rvt_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring engine
// Sequencer that walks the version ring one entry per read/check pair,
// sharing one ring memory across the request kinds and one count adder between begin and end reads.
// ----------------------------------------------------------------------------
module rvt_engine
   import rvt_pkg::*;
#(
   parameter int DEPTH = RVT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  rvt_cmd_type cmd,
   output rvt_res_type res,
   output logic        busy
);

   localparam int SW = $clog2(DEPTH);
   localparam int PW = SW + 1;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_BR_RD   = 10'b00_0000_0010,
      ST_BR_CHK  = 10'b00_0000_0100,
      ST_ER_RD   = 10'b00_0000_1000,
      ST_ER_CHK  = 10'b00_0001_0000,
      ST_POP_RD  = 10'b00_0010_0000,
      ST_POP_CHK = 10'b00_0100_0000,
      ST_CM_RD   = 10'b00_1000_0000,
      ST_CM_CHK  = 10'b01_0000_0000,
      ST_DONE    = 10'b10_0000_0000
   } eng_state_type;

   eng_state_type state_ff, state_in;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [PW-1:0] p_ff, p_in;
   logic [31:0]   rver_ff, rver_in;
   logic [1:0]    status_ff, status_in;
   logic          empty_ff, empty_in;
   logic [31:0]   oldest_ff, oldest_in;

   logic [PW-1:0] used;
   logic [SW-1:0] prev_slot;
   logic          wr_en;
   logic [SW-1:0] wr_addr;
   rvt_entry_type wr_data;
   logic [SW-1:0] rd_addr;
   rvt_entry_type rd_data;
   logic          cnt_dec;
   logic [31:0]   cnt_sum;

   // Pointers carry a wrap bit above the slot number.
   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p[SW-1:0] == SW'(DEPTH - 1)) begin
         r = {~p[SW], {SW{1'b0}}};
      end else begin
         r = p + PW'(1);
      end
      return r;
   endfunction

   always_comb begin
      if (head_ff[SW] == tail_ff[SW]) begin
         used = PW'(tail_ff[SW-1:0]) - PW'(head_ff[SW-1:0]);
      end else begin
         used = PW'(DEPTH) - PW'(head_ff[SW-1:0]) + PW'(tail_ff[SW-1:0]);
      end
      if (tail_ff[SW-1:0] == '0) begin
         prev_slot = SW'(DEPTH - 1);
      end else begin
         prev_slot = tail_ff[SW-1:0] - SW'(1);
      end
   end

   // The single count adder: increment on a reader bump, decrement on release.
   assign cnt_sum = rd_data.count + (cnt_dec ? 32'hFFFF_FFFF : 32'd1);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      p_in      = p_ff;
      rver_in   = rver_ff;
      status_in = status_ff;
      empty_in  = empty_ff;
      oldest_in = oldest_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_ff[SW-1:0];
      wr_data   = rd_data;
      rd_addr   = head_ff[SW-1:0];
      cnt_dec   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd.go) begin
               rver_in   = cmd.reader_version;
               status_in = STATUS_OK;
               p_in      = head_ff;
               empty_in  = (used == '0);
               oldest_in = '0;
               case (cmd.kind)
                  KIND_BEGIN_READ: state_in = ST_BR_RD;
                  KIND_END_READ:   state_in = ST_ER_RD;
                  KIND_COMMIT:     state_in = ST_CM_RD;
                  default:         state_in = ST_DONE;
               endcase
            end
         end
         ST_BR_RD: begin
            rd_addr  = prev_slot;
            state_in = ST_BR_CHK;
         end
         ST_BR_CHK: begin
            if (used != '0 && rd_data.version == cmd.cur_version) begin
               wr_en         = 1'b1;
               wr_addr       = prev_slot;
               wr_data.count = cnt_sum;
            end else if (used == PW'(DEPTH)) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               wr_en           = 1'b1;
               wr_addr         = tail_ff[SW-1:0];
               wr_data.version = cmd.cur_version;
               wr_data.count   = 32'd1;
               tail_in         = ptr_next(tail_ff);
            end
            state_in = ST_DONE;
         end
         ST_ER_RD: begin
            rd_addr = p_ff[SW-1:0];
            if (p_ff == tail_ff) begin
               status_in = STATUS_NOT_FOUND;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_ER_CHK;
            end
         end
         ST_ER_CHK: begin
            if (rd_data.version == rver_ff) begin
               if (p_ff == head_ff && rd_data.count == 32'd1) begin
                  head_in  = ptr_next(head_ff);
                  state_in = ST_POP_RD;
               end else begin
                  if (rd_data.count != '0) begin
                     cnt_dec       = 1'b1;
                     wr_en         = 1'b1;
                     wr_addr       = p_ff[SW-1:0];
                     wr_data.count = cnt_sum;
                  end
                  state_in = ST_DONE;
               end
            end else begin
               p_in     = ptr_next(p_ff);
               state_in = ST_ER_RD;
            end
         end
         ST_POP_RD: begin
            rd_addr = head_ff[SW-1:0];
            if (head_ff == tail_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_POP_CHK;
            end
         end
         ST_POP_CHK: begin
            if (rd_data.count == '0) begin
               head_in  = ptr_next(head_ff);
               state_in = ST_POP_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CM_RD: begin
            rd_addr  = head_ff[SW-1:0];
            state_in = ST_CM_CHK;
         end
         ST_CM_CHK: begin
            oldest_in = rd_data.version;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      rver_ff   <= rver_in;
      status_ff <= status_in;
      empty_ff  <= empty_in;
      oldest_ff <= oldest_in;
   end

   rvt_ring_ram #(
      .DEPTH (DEPTH)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy             = (state_ff != ST_IDLE);
   assign res.done         = (state_ff == ST_DONE);
   assign res.status       = status_ff;
   assign res.ring_empty   = empty_ff;
   assign res.head_version = oldest_ff;

endmodule

>>> tb/sv/rvt_snapshot_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader version tracker checker
// Watches the request and response channels. It keeps its own copy of the
// reader ring and snapshot registers and works out the response of each
// accepted request. It then compares every response, field by field, with
// the oldest one still awaited.
// ----------------------------------------------------------------------------
module rvt_snapshot_checker
   import rvt_pkg::*;
#(
   parameter int DEPTH = RVT_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  rvt_req_type req_item,
   input  logic        rsp_valid,
   input  rvt_rsp_type rsp_item,
   output int          pending_count,
   output int          mismatch_count
);

   // Ring pointers carry one wrap bit above the slot number.
   localparam int unsigned PTR_SPAN = 2 * DEPTH;

   logic [31:0] ring_version [DEPTH];
   logic [31:0] ring_count [DEPTH];
   int unsigned head_ptr;
   int unsigned tail_ptr;
   logic [31:0] cur_version;
   logic [63:0] cur_top_ref;
   logic [63:0] cur_file_size;
   rvt_rsp_type awaited_snapshots [$];

   initial mismatch_count = 0;

   function automatic rvt_rsp_type predict_snapshot(input rvt_req_type r);
      rvt_rsp_type rsp;
      int unsigned used;
      int unsigned p;
      int unsigned s;
      int unsigned i;
      bit hit;
      logic [31:0] nv;
      rsp = '0;
      rsp.status = STATUS_OK;
      used = (tail_ptr + PTR_SPAN - head_ptr) % PTR_SPAN;
      case (r.kind)
         KIND_BEGIN_READ: begin
            rsp.snapshot_version = cur_version;
            rsp.snapshot_top_ref = cur_top_ref;
            rsp.snapshot_file_size = cur_file_size;
            s = ((tail_ptr + PTR_SPAN - 1) % PTR_SPAN) % DEPTH;
            if (used != 0 && ring_version[s] == cur_version) begin
               ring_count[s] = ring_count[s] + 32'd1;
            end else if (used >= DEPTH) begin
               rsp.status = STATUS_OVERFLOW;
            end else begin
               s = tail_ptr % DEPTH;
               ring_version[s] = cur_version;
               ring_count[s] = 32'd1;
               tail_ptr = (tail_ptr + 1) % PTR_SPAN;
            end
         end
         KIND_END_READ: begin
            p = head_ptr;
            hit = 1'b0;
            for (i = 0; i < used && !hit; i++) begin
               if (ring_version[p % DEPTH] == r.reader_version) hit = 1'b1;
               else p = (p + 1) % PTR_SPAN;
            end
            if (!hit) begin
               rsp.status = STATUS_NOT_FOUND;
            end else begin
               s = p % DEPTH;
               if (p == head_ptr && ring_count[s] == 32'd1) begin
                  // Releasing the oldest reader also drops any emptied
                  // entries right behind it.
                  head_ptr = (head_ptr + 1) % PTR_SPAN;
                  while (head_ptr != tail_ptr && ring_count[head_ptr % DEPTH] == '0)
                     head_ptr = (head_ptr + 1) % PTR_SPAN;
               end else if (ring_count[s] != '0) begin
                  ring_count[s] = ring_count[s] - 32'd1;
               end
            end
         end
         KIND_COMMIT: begin
            nv = cur_version + 32'd1;
            rsp.snapshot_version = nv;
            rsp.oldest_locked_version = (used == 0) ? nv : ring_version[head_ptr % DEPTH];
            cur_top_ref = r.new_top_ref;
            cur_file_size = r.new_file_size;
            cur_version = nv;
         end
         default: ;
      endcase
      return rsp;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rvt_rsp_type want;
      if (reset) begin
         head_ptr = 0;
         tail_ptr = 0;
         cur_version = '0;
         cur_top_ref = '0;
         cur_file_size = '0;
         awaited_snapshots.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_snapshots.size() == 0) begin
               $error("response arrived with no request outstanding");
               mismatch_count++;
            end else begin
               want = awaited_snapshots.pop_front();
               check_field("snapshot_version", 64'(want.snapshot_version),
                           64'(rsp_item.snapshot_version));
               check_field("oldest_locked_version", 64'(want.oldest_locked_version),
                           64'(rsp_item.oldest_locked_version));
               check_field("snapshot_top_ref", want.snapshot_top_ref,
                           rsp_item.snapshot_top_ref);
               check_field("snapshot_file_size", want.snapshot_file_size,
                           rsp_item.snapshot_file_size);
               check_field("status", 64'(want.status), 64'(rsp_item.status));
            end
         end
         if (start && !busy) awaited_snapshots.push_back(predict_snapshot(req_item));
      end
      pending_count <= awaited_snapshots.size();
   end

endmodule

>>> tb/sv/tb_reader_version_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reader version tracker testbench
// Drives begin read, end read and commit requests into the tracker. A
// short directed run comes first, then three phases of random reader
// traffic with different idle rates. A checker beside the block predicts
// and compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_reader_version_tracker;
   import rvt_pkg::*;

   // The package names no code for the fourth request kind. The block must
   // treat it as a no-op that returns an all-zero response.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   rvt_req_type req_item;
   logic        rsp_valid;
   rvt_rsp_type rsp_item;
   int          pending_count;
   int          mismatch_count;

   // Stimulus bookkeeping only. It tracks which versions readers have
   // opened, so that most end reads name a version that really is in use.
   // It does not predict responses. The checker does that.
   logic [31:0] stim_version;
   logic [31:0] open_readers [$];
   int          idle_pct;
   int          sent_count;

   reader_version_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   rvt_snapshot_checker #(.DEPTH(RVT_DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .pending_count  (pending_count),
      .mismatch_count (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog. A correct run needs only a few milliseconds, even when
   // every end read walks the whole ring.
   initial begin
      #15_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Returns a 64-bit word that is often one of the two extremes.
   function automatic logic [63:0] pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Presents one request and returns at the edge that accepts it. Start is
   // left high, so a request that follows at once goes out back to back.
   // Within this task it is only lowered when an idle gap is drawn.
   task automatic send_request(input logic [1:0] kind, input logic [31:0] version,
                               input logic [63:0] top_ref, input logic [63:0] size_word);
      rvt_req_type r;
      int gap;
      r.kind = kind;
      r.reader_version = version;
      r.new_top_ref = top_ref;
      r.new_file_size = size_word;
      gap = 0;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind == KIND_BEGIN_READ) open_readers.push_back(stim_version);
      else if (kind == KIND_COMMIT) stim_version++;
      sent_count++;
   endtask

   task automatic request_reader();
      send_request(KIND_BEGIN_READ, $urandom, pick_word(), pick_word());
   endtask

   task automatic commit_snapshot();
      send_request(KIND_COMMIT, $urandom, pick_word(), pick_word());
   endtask

   // Ends a randomly chosen open reader. The choice is random so that
   // releases hit the oldest entry as well as entries further back.
   task automatic end_read_open();
      int idx;
      logic [31:0] v;
      if (open_readers.size() == 0) begin
         request_reader();
      end else begin
         idx = $urandom_range(open_readers.size() - 1);
         v = open_readers[idx];
         open_readers.delete(idx);
         send_request(KIND_END_READ, v, pick_word(), pick_word());
      end
   endtask

   // Stops sending until every outstanding response has come back.
   task automatic drain_responses();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // One request from a mix that is mostly well formed. The rest is noise:
   // end reads of versions nobody holds, and unused kinds.
   task automatic random_request();
      int w;
      w = $urandom_range(99);
      if (open_readers.size() > 80) w = 50;
      if (w < 35 || (w < 65 && open_readers.size() == 0)) request_reader();
      else if (w < 65) end_read_open();
      else if (w < 85) commit_snapshot();
      else if (w < 93) send_request(KIND_END_READ, $urandom, pick_word(), pick_word());
      else if (w < 97) send_request(KIND_UNUSED, $urandom, pick_word(), pick_word());
      else send_request(KIND_END_READ, stim_version + 32'd1, pick_word(), pick_word());
   endtask

   task automatic run_phase(input int pct, input int n_items);
      int stop_at;
      int w;
      idle_pct = pct;
      stop_at = sent_count + n_items;
      while (sent_count < stop_at) begin
         w = $urandom_range(99);
         if (w < 50) begin
            repeat ($urandom_range(30, 8)) random_request();
         end else if (w < 65) begin
            // Open a reader on each of RVT_DEPTH - 2 to RVT_DEPTH + 4 versions.
            // Where that exceeds what the ring holds, the last begin reads overflow.
            // Releasing the readers in random order then leaves runs of empty entries behind the oldest one.
            repeat ($urandom_range(RVT_DEPTH + 4, RVT_DEPTH - 2)) begin
               request_reader();
               if ($urandom_range(3) == 0) request_reader();
               commit_snapshot();
            end
            while (open_readers.size() > 0) begin
               if ($urandom_range(9) == 0) commit_snapshot();
               else end_read_open();
            end
         end else if (w < 85) begin
            // Many readers share one version.
            repeat ($urandom_range(12, 2)) request_reader();
            if ($urandom_range(1) == 0) commit_snapshot();
            while (open_readers.size() > 0 && $urandom_range(7) != 0) end_read_open();
         end else begin
            drain_responses();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      idle_pct = 0;
      sent_count = 0;
      stim_version = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. The version numbers below follow from reset. The
      // first begin read sees the cleared snapshot on an empty ring.
      idle_pct = 14;
      send_request(KIND_BEGIN_READ, '1, '1, '1);
      send_request(KIND_COMMIT, '0, '1, '1);
      send_request(KIND_BEGIN_READ, '0, '0, '0);
      send_request(KIND_BEGIN_READ, '1, '1, '1);
      send_request(KIND_COMMIT, '1, '0, '0);
      send_request(KIND_BEGIN_READ, '0, '1, '0);
      // Release a newer reader, then release it again. The count must
      // stick at zero.
      send_request(KIND_END_READ, 32'd2, '0, '1);
      send_request(KIND_END_READ, 32'd2, '1, '0);
      // A version that nobody holds is reported as not found.
      send_request(KIND_END_READ, '1, '0, '0);
      send_request(KIND_END_READ, 32'd1, pick_word(), pick_word());
      send_request(KIND_END_READ, 32'd1, pick_word(), pick_word());
      send_request(KIND_UNUSED, '1, '1, '1);
      send_request(KIND_UNUSED, '0, '0, '0);
      // Commit with readers open reports the oldest one, version 0.
      send_request(KIND_COMMIT, $urandom, pick_word(), pick_word());
      // Releasing version 0 pops it together with the two emptied entries
      // behind it, which leaves the ring empty.
      send_request(KIND_END_READ, 32'd0, pick_word(), pick_word());
      // On an empty ring, commit reports the new version as the oldest.
      send_request(KIND_COMMIT, $urandom, pick_word(), pick_word());
      send_request(KIND_END_READ, 32'd0, pick_word(), pick_word());
      send_request(KIND_BEGIN_READ, $urandom, pick_word(), pick_word());
      send_request(KIND_END_READ, stim_version, pick_word(), pick_word());
      open_readers.delete();
      drain_responses();

      // Random part. The sender is mostly busy in the first phase, mostly
      // idle in the second, and draws no idle gaps in the third.
      run_phase(14, 550);
      drain_responses();
      run_phase(64, 550);
      drain_responses();
      run_phase(0, 550);

      // The longest end read walks or pops the whole ring.
      drain_responses();
      repeat (4 * RVT_DEPTH + 20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
